[hw/rtl/brm_pkg.sv]
`default_nettype none

package brm_pkg;

    // operation codes
    typedef enum logic [3:0] {
        OP_ADDR = 4'd0,
        OP_ADDI = 4'd1,
        OP_MULR = 4'd2,
        OP_MULI = 4'd3,
        OP_BANR = 4'd4,
        OP_BANI = 4'd5,
        OP_BORR = 4'd6,
        OP_BORI = 4'd7,
        OP_SETR = 4'd8,
        OP_SETI = 4'd9,
        OP_GTIR = 4'd10,
        OP_GTRI = 4'd11,
        OP_GTRR = 4'd12,
        OP_EQIR = 4'd13,
        OP_EQRI = 4'd14,
        OP_EQRR = 4'd15
    } op_t;

    // configuration register indexes
    localparam logic [0:0] CFG_IP_BINDING     = 1'd0;
    localparam logic [0:0] CFG_PROGRAM_LENGTH = 1'd1;

    localparam int CFG_DATA_W = 9;

    localparam logic [2:0] IP_BINDING_RESET     = 3'd0;
    localparam logic [8:0] PROGRAM_LENGTH_RESET = 9'd1;

    typedef struct packed {
        op_t                op_code;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic        [2:0]  dest_index;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] next_pointer;
        logic               halted;
        logic signed [31:0] written_value;
        logic signed [31:0] first_register;
        logic               index_fault;
    } out_word_t;

endpackage

`default_nettype wire

[hw/rtl/bound_ip_register_machine_execute_unit.sv]
`default_nettype none

// Execute unit of a small register machine whose instruction pointer is
// mirrored in one register (the bound register, chosen by ip_binding).
// Each input word is the instruction fetched at the current pointer; the
// unit copies the pointer into the bound register, applies one of sixteen
// register/immediate operations (add, multiply, and, or, set, signed
// greater-than, equal; 32-bit wrapping), writes the destination, and
// reports the next pointer (bound register plus one, or pointer plus one
// when unbound). A next pointer outside 0..program_length-1 halts the
// machine for good: later words are still taken and answered, but change
// nothing. Out-of-range register indexes read as zero and raise
// index_fault; an out-of-range destination suppresses the write.
// Throughput is one word per clock while out_stall is low: a word sits in
// the input register while the whole operation (register read, one 32x32
// multiplier, write-back) runs, and the result lands in the output
// register, taken from there when out_stall is low. The dependency through
// the register file and pointer, closed within the execute stage, sets the
// rate. Configuration is written through cfg_write/cfg_index/cfg_data; the
// user must write it only while the unit is idle: the unit does not check.
module bound_ip_register_machine_execute_unit
    import brm_pkg::*;
#(
    parameter int REGISTER_COUNT = 6,
    parameter int MAX_PROGRAM    = 256
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // instruction words
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_word_t              in_data,
    // result words
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_word_t                  out_data,
    // configuration writes
    input  wire logic                  cfg_write,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RIDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int LEN_W  = $clog2(MAX_PROGRAM + 1);

    // configuration
    logic [2:0]            ip_binding_reg;
    logic [CFG_DATA_W-1:0] program_length_reg;

    // machine state
    logic [31:0] rf_reg [REGISTER_COUNT];
    logic [31:0] rf_next [REGISTER_COUNT];
    logic [31:0] ip_reg;
    logic [31:0] ip_next;
    logic        halt_reg;
    logic        halt_next;

    // pipeline registers
    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    out_word_t out_word_next;

    // execute-stage signals
    logic              advance;
    logic              step;
    logic [LEN_W-1:0]  eff_len;
    logic              ip_outside;
    logic              halt_pre;
    logic              bound;
    logic [RIDX_W-1:0] bind_idx;
    logic [31:0]       rf_view [REGISTER_COUNT];
    logic [31:0]       opa;
    logic [31:0]       opb;
    logic              ra_ok;
    logic              rb_ok;
    logic [31:0]       ra_val;
    logic [31:0]       rb_val;
    logic              uses_ra;
    logic              uses_rb;
    logic              dest_ok;
    logic [RIDX_W-1:0] dest_idx;
    logic [31:0]       mul_b;
    logic [31:0]       mul_lo;
    logic [31:0]       cmp_x;
    logic [31:0]       cmp_y;
    logic              cmp_gt;
    logic              cmp_eq;
    logic [31:0]       res;
    logic              fault;
    logic [31:0]       next_ptr;

    // the execute stage moves when the output register is free or being drained
    assign advance   = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // program length clamps at MAX_PROGRAM
    always_comb
    begin
        if (32'(program_length_reg) > 32'(MAX_PROGRAM))
        begin
            eff_len = LEN_W'(MAX_PROGRAM);
        end
        else
        begin
            eff_len = LEN_W'(program_length_reg);
        end
    end

    // a pointer already outside the program halts without executing
    assign ip_outside = ip_reg >= 32'(eff_len);
    assign halt_pre   = halt_reg || ip_outside;

    assign bound    = 32'(ip_binding_reg) < 32'(REGISTER_COUNT);
    assign bind_idx = ip_binding_reg[RIDX_W-1:0];

    // register file as seen after the pointer copy
    always_comb
    begin
        for (int i = 0; i < REGISTER_COUNT; i++)
        begin
            if (bound && (bind_idx == RIDX_W'(i)))
            begin
                rf_view[i] = ip_reg;
            end
            else
            begin
                rf_view[i] = rf_reg[i];
            end
        end
    end

    // operand reads, out-of-range (including negative) reads as zero
    assign opa    = in_word_reg.operand_a;
    assign opb    = in_word_reg.operand_b;
    assign ra_ok  = opa < 32'(REGISTER_COUNT);
    assign rb_ok  = opb < 32'(REGISTER_COUNT);
    assign ra_val = ra_ok ? rf_view[opa[RIDX_W-1:0]] : 32'd0;
    assign rb_val = rb_ok ? rf_view[opb[RIDX_W-1:0]] : 32'd0;

    assign dest_ok  = 32'(in_word_reg.dest_index) < 32'(REGISTER_COUNT);
    assign dest_idx = in_word_reg.dest_index[RIDX_W-1:0];

    // which operands are register reads
    always_comb
    begin
        uses_ra = !(in_word_reg.op_code inside {OP_SETI, OP_GTIR, OP_EQIR});
        uses_rb = in_word_reg.op_code inside {OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
                                               OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR};
    end

    // one shared multiplier, low half kept
    assign mul_b  = (in_word_reg.op_code == OP_MULI) ? opb : rb_val;
    assign mul_lo = 32'(ra_val * mul_b);

    // one shared operand selection for the gt and eq comparisons
    assign cmp_x  = (in_word_reg.op_code inside {OP_GTIR, OP_EQIR}) ? opa : ra_val;
    assign cmp_y  = (in_word_reg.op_code inside {OP_GTRI, OP_EQRI}) ? opb : rb_val;
    assign cmp_gt = $signed(cmp_x) > $signed(cmp_y);
    assign cmp_eq = cmp_x == cmp_y;

    always_comb
    begin
        case (in_word_reg.op_code)
            OP_ADDR: res = ra_val + rb_val;
            OP_ADDI: res = ra_val + opb;
            OP_MULR: res = mul_lo;
            OP_MULI: res = mul_lo;
            OP_BANR: res = ra_val & rb_val;
            OP_BANI: res = ra_val & opb;
            OP_BORR: res = ra_val | rb_val;
            OP_BORI: res = ra_val | opb;
            OP_SETR: res = ra_val;
            OP_SETI: res = opa;
            OP_GTIR: res = {31'd0, cmp_gt};
            OP_GTRI: res = {31'd0, cmp_gt};
            OP_GTRR: res = {31'd0, cmp_gt};
            OP_EQIR: res = {31'd0, cmp_eq};
            OP_EQRI: res = {31'd0, cmp_eq};
            OP_EQRR: res = {31'd0, cmp_eq};
            default: res = 32'd0;
        endcase
    end

    assign fault = (uses_ra && !ra_ok) || (uses_rb && !rb_ok) || !dest_ok;

    // write-back: destination wins over the pointer copy
    always_comb
    begin
        for (int i = 0; i < REGISTER_COUNT; i++)
        begin
            if (halt_pre)
            begin
                rf_next[i] = rf_reg[i];
            end
            else if (dest_ok && (dest_idx == RIDX_W'(i)))
            begin
                rf_next[i] = res;
            end
            else
            begin
                rf_next[i] = rf_view[i];
            end
        end
    end

    // next pointer follows the bound register, or plain increment when unbound
    assign next_ptr = (bound ? rf_next[bind_idx] : ip_reg) + 32'd1;

    always_comb
    begin
        if (halt_pre)
        begin
            ip_next   = ip_reg;
            halt_next = 1'b1;
            out_word_next.next_pointer   = ip_reg;
            out_word_next.halted         = 1'b1;
            out_word_next.written_value  = 32'd0;
            out_word_next.first_register = rf_reg[0];
            out_word_next.index_fault    = 1'b0;
        end
        else
        begin
            ip_next   = next_ptr;
            halt_next = next_ptr >= 32'(eff_len);
            out_word_next.next_pointer   = next_ptr;
            out_word_next.halted         = halt_next;
            out_word_next.written_value  = res;
            out_word_next.first_register = rf_next[0];
            out_word_next.index_fault    = fault;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_binding_reg     <= IP_BINDING_RESET;
            program_length_reg <= PROGRAM_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IP_BINDING:     ip_binding_reg     <= cfg_data[2:0];
                CFG_PROGRAM_LENGTH: program_length_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // machine state, updated once per executed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                rf_reg[i] <= 32'd0;
            end
            ip_reg   <= 32'd0;
            halt_reg <= 1'b0;
        end
        else if (step)
        begin
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                rf_reg[i] <= rf_next[i];
            end
            ip_reg   <= ip_next;
            halt_reg <= halt_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_word_reg <= in_data;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

`default_nettype wire
